/* rtl/mmc3_pkg.sv */
// Shared types, register decode constants and bank reset table for the MMC3 mapper.
package mmc3_pkg;

    // Bank register store geometry
    localparam int BANK_DEPTH = 8;
    localparam int BANK_IDX_W = $clog2(BANK_DEPTH);
    localparam int BANK_W     = 8;

    // Register decode: CPU address masked with REG_DECODE_MASK
    localparam logic [15:0] REG_DECODE_MASK = 16'hE001;
    localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
    localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
    localparam logic [15:0] REG_MIRROR      = 16'hA000;
    localparam logic [15:0] REG_RAM_CTRL    = 16'hA001;
    localparam logic [15:0] REG_RELOAD_VAL  = 16'hC000;
    localparam logic [15:0] REG_RELOAD_REQ  = 16'hC001;
    localparam logic [15:0] REG_IRQ_OFF     = 16'hE000;
    localparam logic [15:0] REG_IRQ_ON      = 16'hE001;

    // Bank select bits
    localparam int SEL_PRG_SWAP_BIT   = 6;
    localparam int SEL_CHR_INVERT_BIT = 7;

    // Fixed program bank (second to last) and pattern pair mask
    localparam logic [BANK_W-1:0] PRG_FIXED_BANK = 8'hFE;
    localparam logic [BANK_W-1:0] CHR_PAIR_MASK  = 8'hFE;

    typedef enum logic [2:0] {
        OP_REG_WRITE = 3'd0,
        OP_TICK      = 3'd1,
        OP_PRG_MAP   = 3'd2,
        OP_CHR_MAP   = 3'd3,
        OP_RAM_READ  = 3'd4,
        OP_RAM_WRITE = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        VAR_STANDARD = 2'd0,
        VAR_NEC      = 2'd1,
        VAR_AX5202P  = 2'd2,
        VAR_MMC6     = 2'd3
    } variant_t;

    // Where the result bank number comes from in the second stage
    typedef enum logic [1:0] {
        SRC_FIXED    = 2'd0,
        SRC_RAM      = 2'd1,
        SRC_RAM_PAIR = 2'd2
    } bank_src_t;

    // Access to the bank register store
    typedef struct packed {
        logic                  wr_en;
        logic                  rd_en;
        logic [BANK_IDX_W-1:0] idx;
        logic [BANK_W-1:0]     wdata;
    } mem_req_t;

    // Partial result carried from the decode stage to the result stage
    typedef struct packed {
        bank_src_t         src;
        logic [BANK_W-1:0] fixed_bank;
        logic              low_bit;
        logic              irq;
        logic              mirror;
        logic              allowed;
        logic [7:0]        open_bus;
    } pipe_t;

    // Power-up contents of the bank registers
    function automatic logic [BANK_W-1:0] bank_init(input logic [BANK_IDX_W-1:0] idx);
        logic [BANK_W-1:0] val;
        case (idx)
            3'd0:    val = 8'd0;
            3'd1:    val = 8'd2;
            3'd2:    val = 8'd4;
            3'd3:    val = 8'd5;
            3'd4:    val = 8'd6;
            3'd5:    val = 8'd7;
            3'd6:    val = 8'd0;
            3'd7:    val = 8'd1;
            default: val = 8'd0;
        endcase
        return val;
    endfunction

endpackage

/* rtl/mmc3_ram.sv */
// Generic single-port-write, registered-read synchronous RAM.
module mmc3_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/mmc3_bank_store.sv */
// Bank register store: RAM plus per-entry written flags that stand in for reset values.
module mmc3_bank_store (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mmc3_pkg::mem_req_t                  req,
    output logic [mmc3_pkg::BANK_W-1:0]         rdata
);

    import mmc3_pkg::*;

    logic [BANK_DEPTH-1:0] written_reg;
    logic [BANK_DEPTH-1:0] written_next;
    logic                  rd_written_reg;
    logic [BANK_IDX_W-1:0] rd_idx_reg;
    logic [BANK_W-1:0]     ram_q;

    mmc3_ram #(
        .DEPTH (BANK_DEPTH),
        .WIDTH (BANK_W)
    ) u_ram (
        .clk   (clk),
        .we    (req.wr_en),
        .waddr (req.idx),
        .wdata (req.wdata),
        .re    (req.rd_en),
        .raddr (req.idx),
        .rdata (ram_q)
    );

    // Mark entries once written
    always_comb
    begin
        written_next = written_reg;
        if (req.wr_en)
        begin
            written_next[req.idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else
        begin
            written_reg <= written_next;
        end
    end

    // Read side info, aligned with the RAM output register
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_written_reg <= written_reg[req.idx];
            rd_idx_reg     <= req.idx;
        end
    end

    assign rdata = rd_written_reg ? ram_q : bank_init(rd_idx_reg);

endmodule

/* rtl/mmc3_ctrl.sv */
// Operation decode, mapper control registers, scanline counter and bank address generation.
module mmc3_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  mmc3_pkg::op_t       op,
    input  logic [15:0]         addr,
    input  logic [7:0]          data,
    input  logic [2:0]          window,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_data,
    output mmc3_pkg::mem_req_t  req,
    output mmc3_pkg::pipe_t     pipe
);

    import mmc3_pkg::*;

    variant_t    variant_reg;
    logic [7:0]  select_reg,     select_next;
    logic        mirror_reg,     mirror_next;
    logic [1:0]  ram_ctrl_reg,   ram_ctrl_next;
    logic [7:0]  reload_val_reg, reload_val_next;
    logic        reload_pend_reg, reload_pend_next;
    logic        irq_en_reg,     irq_en_next;
    logic [7:0]  counter_reg,    counter_next;
    logic        irq_pend_reg,   irq_pend_next;

    logic [7:0]  counter_tick;
    logic        ram_en;
    logic        ram_wp;
    logic [1:0]  prg_w;
    logic [2:0]  chr_w;

    assign ram_en = ram_ctrl_reg[1];
    assign ram_wp = ram_ctrl_reg[0];

    // Counter value after a scanline tick
    assign counter_tick = (reload_pend_reg || counter_reg == 8'd0) ? reload_val_reg
                                                                    : counter_reg - 8'd1;

    // Window remapping from the bank select mode bits
    always_comb
    begin
        prg_w = window[1:0];
        if (select_reg[SEL_PRG_SWAP_BIT] && !prg_w[0])
        begin
            prg_w[1] = ~prg_w[1];
        end
        chr_w = window ^ {select_reg[SEL_CHR_INVERT_BIT], 2'b00};
    end

    // Next state and partial result
    always_comb
    begin
        select_next      = select_reg;
        mirror_next      = mirror_reg;
        ram_ctrl_next    = ram_ctrl_reg;
        reload_val_next  = reload_val_reg;
        reload_pend_next = reload_pend_reg;
        irq_en_next      = irq_en_reg;
        counter_next     = counter_reg;
        irq_pend_next    = irq_pend_reg;
        req              = '0;
        pipe             = '0;
        pipe.src         = SRC_FIXED;

        case (op)
            OP_REG_WRITE:
            begin
                case (addr & REG_DECODE_MASK)
                    REG_BANK_SELECT: select_next = data;
                    REG_BANK_DATA:
                    begin
                        req.wr_en = 1'b1;
                        req.idx   = select_reg[BANK_IDX_W-1:0];
                        req.wdata = data;
                    end
                    REG_MIRROR:      mirror_next = data[0];
                    REG_RAM_CTRL:    ram_ctrl_next = data[7:6];
                    REG_RELOAD_VAL:  reload_val_next = data;
                    REG_RELOAD_REQ:
                    begin
                        reload_pend_next = 1'b1;
                        counter_next     = 8'd0;
                    end
                    REG_IRQ_OFF:
                    begin
                        irq_pend_next = 1'b0;
                        irq_en_next   = 1'b0;
                    end
                    REG_IRQ_ON:      irq_en_next = 1'b1;
                    default: ;
                endcase
            end
            OP_TICK:
            begin
                counter_next     = counter_tick;
                reload_pend_next = 1'b0;
                // NEC parts skip the IRQ when the counter was already zero without reload
                if ((counter_reg != 8'd0 || variant_reg != VAR_NEC || reload_pend_reg) &&
                    counter_tick == 8'd0 && irq_en_reg)
                begin
                    irq_pend_next = 1'b1;
                end
            end
            OP_PRG_MAP:
            begin
                if (prg_w[1])
                begin
                    pipe.fixed_bank = PRG_FIXED_BANK | {7'd0, prg_w[0]};
                end
                else
                begin
                    req.rd_en = 1'b1;
                    req.idx   = {2'b11, prg_w[0]};
                    pipe.src  = SRC_RAM;
                end
            end
            OP_CHR_MAP:
            begin
                req.rd_en = 1'b1;
                if (chr_w[2])
                begin
                    req.idx  = chr_w - 3'd2;
                    pipe.src = SRC_RAM;
                end
                else
                begin
                    req.idx      = {1'b0, chr_w[2:1]};
                    pipe.src     = SRC_RAM_PAIR;
                    pipe.low_bit = chr_w[0];
                end
            end
            OP_RAM_READ:
            begin
                pipe.allowed = ram_en || variant_reg == VAR_AX5202P || variant_reg == VAR_MMC6;
                if (!pipe.allowed)
                begin
                    pipe.open_bus = addr[15:8];
                end
            end
            OP_RAM_WRITE:
            begin
                pipe.allowed = ((ram_en || variant_reg == VAR_AX5202P) && !ram_wp) ||
                               variant_reg == VAR_MMC6;
            end
            default: ;
        endcase

        pipe.irq    = irq_pend_next;
        pipe.mirror = mirror_next;

        if (!accept)
        begin
            req.wr_en = 1'b0;
            req.rd_en = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg     <= VAR_STANDARD;
            select_reg      <= 8'd0;
            mirror_reg      <= 1'b0;
            ram_ctrl_reg    <= 2'd0;
            reload_val_reg  <= 8'd0;
            reload_pend_reg <= 1'b0;
            irq_en_reg      <= 1'b0;
            counter_reg     <= 8'd0;
            irq_pend_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                variant_reg <= variant_t'(cfg_wr_data);
            end
            if (accept)
            begin
                select_reg      <= select_next;
                mirror_reg      <= mirror_next;
                ram_ctrl_reg    <= ram_ctrl_next;
                reload_val_reg  <= reload_val_next;
                reload_pend_reg <= reload_pend_next;
                irq_en_reg      <= irq_en_next;
                counter_reg     <= counter_next;
                irq_pend_reg    <= irq_pend_next;
            end
        end
    end

endmodule

/* rtl/mmc3_bank_mapper_irq.sv */
// Pipeline: an accepted transaction goes into the decode stage registers, then into the output
// register; one transaction per cycle while the output does not stall. The bank store is read at
// most once per map op, its registered read in the second stage, writes at the accept edge.
// Reset: control registers, scanline counter and IRQ clear; bank registers read back
// their power-up values through per-entry written flags, with no clearing pass.
// Top level of the MMC3 bank mapper with scanline IRQ counter.
module mmc3_bank_mapper_irq (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,   // chip_variant
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // addr[15:0], data[23:16], window[26:24], zero fill
    input  logic [2:0]  s_tuser,       // op[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata        // bank_number[7:0], irq_line[8], mirror_horizontal[9],
                                       // ram_allowed[10], open_bus_value[18:11], zero fill
);

    import mmc3_pkg::*;

    logic              accept;
    logic              adv1;
    mem_req_t          req;
    pipe_t             pipe;
    logic [BANK_W-1:0] store_q;

    logic              v1_reg, v1_next;
    pipe_t             p1_reg;
    logic              out_v_reg, out_v_next;
    logic [23:0]       out_data_reg;
    logic [BANK_W-1:0] bank_res;

    // Handshake
    assign adv1     = !out_v_reg || m_tready;
    assign s_tready = !v1_reg || adv1;
    assign accept   = s_tvalid && s_tready;

    mmc3_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .op          (op_t'(s_tuser)),
        .addr        (s_tdata[15:0]),
        .data        (s_tdata[23:16]),
        .window      (s_tdata[26:24]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .pipe        (pipe)
    );

    mmc3_bank_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rdata (store_q)
    );

    // Result stage: merge store data
    always_comb
    begin
        case (p1_reg.src)
            SRC_RAM:      bank_res = store_q;
            SRC_RAM_PAIR: bank_res = (store_q & CHR_PAIR_MASK) | {7'd0, p1_reg.low_bit};
            default:      bank_res = p1_reg.fixed_bank;
        endcase
    end

    // Valid flags
    always_comb
    begin
        v1_next = v1_reg;
        if (accept)
        begin
            v1_next = 1'b1;
        end
        else if (adv1)
        begin
            v1_next = 1'b0;
        end
        out_v_next = adv1 ? v1_reg : out_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= v1_next;
            out_v_reg <= out_v_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_reg <= pipe;
        end
        if (adv1 && v1_reg)
        begin
            out_data_reg <= {5'd0, p1_reg.open_bus, p1_reg.allowed, p1_reg.mirror,
                             p1_reg.irq, bank_res};
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* rtl/mmc3_checker.sv */
// Port-level checks for the MMC3 mapper, bound to the top level.
module mmc3_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // With the output empty the block always takes input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Open bus value only on a refused RAM read
    a_open_bus: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[18:11] != 8'd0 |-> !m_tdata[10] && m_tdata[7:0] == 8'd0)
        else $error("open bus value with access allowed or bank number");

    // Bank number only for map ops
    a_bank_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[7:0] != 8'd0 |-> !m_tdata[10])
        else $error("bank number together with RAM permission");

    // Upper fill bits stay zero
    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:19] == 5'd0)
        else $error("nonzero fill bits");

endmodule

bind mmc3_bank_mapper_irq mmc3_checker u_mmc3_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
